// ===== rtl/core/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types and constants for the rolling percentile rank block.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int SAMPLE_W = 32;
  localparam int SPAN_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int PCT_W    = 15;
  localparam int SIZE_W   = 9;   // window size, 1..256
  localparam int DVD_W    = 23;  // count * 25600 < 2**23

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SPAN_W-1:0]          span_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [PCT_W-1:0]           pct_t;
  typedef logic [SIZE_W-1:0]          size_t;
  typedef logic [DVD_W-1:0]           dvd_t;

  localparam span_t SPAN_RESET = 8'd52;
  // 100 percent with 8 fraction bits
  localparam logic [PCT_W-1:0] PCT_SCALE = 15'd25600;

endpackage

// ===== rtl/core/rolling_percentile_rank.sv =====
// ----------------------------------------------------------------------------
// rolling_percentile_rank
// Percentile rank of each sample within the last window_span+1 samples.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, sample, restart        to block
//   out       out_valid/out_ready, valid_res,
//             count_below, percentile                   from block
//   cfg       cfg_wr_en, cfg_wr_data (window_span)      to block
//
// One transaction makes one RAM read per earlier window sample (single read
// port, pipelined compare), then runs the bit-serial divider. A result with
// an unfilled window skips both. in_ready is high only while the sequencer
// idles; a finished result waits in the output register while the next
// sample is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rolling_percentile_rank #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  prr_pkg::span_t        cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  prr_pkg::sample_t      sample,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  valid_res,
  output prr_pkg::count_t       count_below,
  output prr_pkg::pct_t         percentile
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int NW = (FW > prr_pkg::SIZE_W) ? FW : prr_pkg::SIZE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]         state;
  prr_pkg::span_t     window_span;
  logic [AW-1:0]      write_slot;
  logic [FW-1:0]      fill_count;
  logic [AW-1:0]      rd_addr;
  prr_pkg::count_t    remain;
  logic               pend;
  prr_pkg::sample_t   key;
  prr_pkg::count_t    count;
  prr_pkg::size_t     window_size;
  logic               res_valid;
  prr_pkg::pct_t      pct;

  logic               accept;
  logic [FW-1:0]      fill_base;
  logic [FW-1:0]      fill_next;
  logic [NW-1:0]      span_ext;
  logic [NW-1:0]      n_full;
  logic               full_next;
  logic               rd_en;
  prr_pkg::sample_t   rd_data;
  logic               scan_end;
  logic               div_done;
  prr_pkg::pct_t      div_q;
  prr_pkg::dvd_t      dividend;
  logic               out_load;

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
    return (s == '0) ? AW'(WINDOW_DEPTH - 1) : s - 1'b1;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  assign fill_base = restart ? '0 : fill_count;
  assign fill_next = (fill_base < FW'(WINDOW_DEPTH)) ? fill_base + 1'b1 : fill_base;
  assign span_ext  = NW'(window_span) + 1'b1;
  assign n_full    = (span_ext > NW'(WINDOW_DEPTH)) ? NW'(WINDOW_DEPTH) : span_ext;
  assign full_next = NW'(fill_next) >= n_full;

  assign rd_en    = (state == ST_SCAN) && (remain != '0);
  assign scan_end = (state == ST_SCAN) && (remain == '0) && !pend;
  assign dividend = prr_pkg::dvd_t'(count) * prr_pkg::dvd_t'(prr_pkg::PCT_SCALE);

  prr_ram #(
    .WIDTH (prr_pkg::SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_slot),
    .wr_data (sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_end),
    .dividend (dividend),
    .divisor  (window_size),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_span <= prr_pkg::SPAN_RESET;
      write_slot  <= '0;
      fill_count  <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_span <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fill_count <= fill_next;
            write_slot <= (write_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
            pend       <= 1'b0;
            state      <= full_next ? ST_SCAN : ST_OUT;
          end
        end
        ST_SCAN: begin
          pend <= rd_en;
          if (scan_end) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key         <= sample;
      rd_addr     <= slot_prev(write_slot);
      window_size <= n_full[prr_pkg::SIZE_W-1:0];
      remain      <= prr_pkg::COUNT_W'(n_full - 1'b1);
      res_valid   <= full_next;
      count       <= '0;
      pct         <= '0;
    end else begin
      if (rd_en) begin
        rd_addr <= slot_prev(rd_addr);
        remain  <= remain - 1'b1;
      end
      // read data lands in the cycle after the address
      if ((state == ST_SCAN) && pend && (rd_data < key)) begin
        count <= count + 1'b1;
      end
      if ((state == ST_DIV) && div_done) begin
        pct <= div_q;
      end
    end
    if (out_load) begin
      valid_res   <= res_valid;
      count_below <= count;
      percentile  <= pct;
    end
  end

endmodule

// ===== rtl/core/prr_ram.sv =====
// ----------------------------------------------------------------------------
// prr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module prr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/prr_div.sv =====
// ----------------------------------------------------------------------------
// prr_div
// Restoring divider, one quotient bit per cycle, for the percentile scaling.
// ----------------------------------------------------------------------------
module prr_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  prr_pkg::dvd_t  dividend,
  input  prr_pkg::size_t divisor,
  output logic           done,
  output prr_pkg::pct_t  quotient
);

  localparam int STEP_W = $clog2(prr_pkg::DVD_W);

  logic                busy;
  logic [STEP_W-1:0]   step;
  prr_pkg::dvd_t       dvd;
  prr_pkg::dvd_t       quo;
  prr_pkg::size_t      rem;
  prr_pkg::size_t      dsr;
  logic [prr_pkg::SIZE_W:0] rem_sh;
  logic                ge;

  assign rem_sh   = {rem, dvd[prr_pkg::DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = quo[prr_pkg::PCT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(prr_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      // remainder stays below divisor <= 256, so 9 bits hold it
      rem <= ge ? prr_pkg::SIZE_W'(rem_sh - {1'b0, dsr}) : rem_sh[prr_pkg::SIZE_W-1:0];
      quo <= {quo[prr_pkg::DVD_W-2:0], ge};
      dvd <= {dvd[prr_pkg::DVD_W-2:0], 1'b0};
    end
  end

endmodule

// ===== bench/rank_checker.sv =====
// ----------------------------------------------------------------------------
// rank_checker
// Watches the config, input and output channels of rolling_percentile_rank,
// keeps its own sample history to predict each result, and compares every
// output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rank_checker #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  prr_pkg::span_t        cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  prr_pkg::sample_t      sample,
  input  logic                  restart,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  valid_res,
  input  prr_pkg::count_t       count_below,
  input  prr_pkg::pct_t         percentile,
  output int                    errors,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            valid;
    prr_pkg::count_t count;
    prr_pkg::pct_t   pct;
  } rank_t;

  rank_t            pending_ranks[$];
  rank_t            want;
  prr_pkg::sample_t history[WINDOW_DEPTH];
  int               wr_slot;
  int               filled;
  prr_pkg::span_t   span;
  int               result_num;

  initial begin
    errors      = 0;
    outstanding = 0;
    result_num  = 0;
    wr_slot     = 0;
    filled      = 0;
    span        = prr_pkg::SPAN_RESET;
  end

  task automatic report(input string msg);
    $display("ERROR: result %0d: %s", result_num, msg);
    errors++;
  endtask

  // Store the sample, then count older window entries strictly below it.
  task automatic predict_rank(input prr_pkg::sample_t s, input logic rs);
    rank_t r;
    int    size;
    int    below;
    r     = '0;
    below = 0;
    size  = int'(span) + 1;
    if (size > WINDOW_DEPTH) size = WINDOW_DEPTH;
    if (rs) filled = 0;
    history[wr_slot] = s;
    if (filled < WINDOW_DEPTH) filled++;
    if (filled >= size) begin
      for (int k = 1; k < size; k++) begin
        if (history[(wr_slot + WINDOW_DEPTH - k) % WINDOW_DEPTH] < s) below++;
      end
      r.valid = 1'b1;
      r.count = prr_pkg::count_t'(below);
      r.pct   = prr_pkg::pct_t'((below * int'(prr_pkg::PCT_SCALE)) / size);
    end
    wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
    pending_ranks = {pending_ranks, r};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_slot = 0;
      filled  = 0;
      span    = prr_pkg::SPAN_RESET;
      pending_ranks.delete();
    end else begin
      if (cfg_wr_en) span = cfg_wr_data;
      // check before predicting: a result can never belong to a same-edge sample
      if (out_valid && out_ready) begin
        if (pending_ranks.size() == 0) begin
          report("output transaction with nothing expected");
        end else begin
          want = pending_ranks.pop_front();
          if (valid_res !== want.valid)
            report($sformatf("valid_res got %0b want %0b", valid_res, want.valid));
          if (count_below !== want.count)
            report($sformatf("count_below got %0d want %0d", count_below, want.count));
          if (percentile !== want.pct)
            report($sformatf("percentile got %0d want %0d", percentile, want.pct));
        end
        result_num++;
      end
      if (in_valid && in_ready) predict_rank(sample, restart);
    end
    outstanding = pending_ranks.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for rolling_percentile_rank: directed corner cases,
// then random phases over several window spans with random gaps on both
// channels and one long output stall. Checking lives in rank_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 256;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 1000;
  localparam int PHASES      = 8;
  localparam prr_pkg::sample_t S_MIN = {1'b1, {(prr_pkg::SAMPLE_W-1){1'b0}}};
  localparam prr_pkg::sample_t S_MAX = {1'b0, {(prr_pkg::SAMPLE_W-1){1'b1}}};

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  prr_pkg::span_t   cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  prr_pkg::sample_t sample;
  logic             restart;
  logic             out_valid;
  logic             out_ready;
  logic             valid_res;
  prr_pkg::count_t  count_below;
  prr_pkg::pct_t    percentile;

  int errors;
  int outstanding;
  bit quiet        = 1'b0;
  int idle_cycles  = 0;
  int rx_count     = 0;

  int phase_span  [PHASES] = '{5, 1, 52, 255, 104, 252, 0, 0};
  int phase_items [PHASES] = '{300, 200, 250, 300, 150, 150, 100, 150};

  rolling_percentile_rank #(.WINDOW_DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .valid_res   (valid_res),
    .count_below (count_below),
    .percentile  (percentile)
  );

  rank_checker #(.WINDOW_DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .valid_res   (valid_res),
    .count_below (count_below),
    .percentile  (percentile),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(40, 120);
  endfunction

  // extremes, a narrow band that yields many ties, and full-range values
  function automatic prr_pkg::sample_t pick_sample();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      k = $urandom_range(0, 3);
      return (k == 0) ? S_MIN : (k == 1) ? S_MAX :
             (k == 2) ? prr_pkg::sample_t'(0) : prr_pkg::sample_t'(-1);
    end
    if (r < 5) return prr_pkg::sample_t'(int'($urandom_range(0, 15)) - 8);
    return prr_pkg::sample_t'($urandom);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input prr_pkg::sample_t s, input logic rs);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= rs;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // span only changes once every result is out
  task automatic set_span(input prr_pkg::span_t v);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int span_now;
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample      = '0;
    restart     = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // window of four: fill, extremes, ties, restart, ascending run
    set_span(prr_pkg::span_t'(3));
    send_item(S_MIN, 1'b1);
    send_item(S_MAX, 1'b0);
    send_item(prr_pkg::sample_t'(0), 1'b0);
    send_item(prr_pkg::sample_t'(-1), 1'b0);
    send_item(prr_pkg::sample_t'(0), 1'b0);
    send_item(prr_pkg::sample_t'(0), 1'b0);
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b0);
    send_item(S_MAX, 1'b1);
    send_item(prr_pkg::sample_t'(1), 1'b0);
    send_item(prr_pkg::sample_t'(2), 1'b0);
    send_item(prr_pkg::sample_t'(3), 1'b0);
    // span of zero, switched in the middle of a series
    set_span(prr_pkg::span_t'(0));
    send_item(prr_pkg::sample_t'(5), 1'b0);
    send_item(S_MIN, 1'b1);
    send_item(S_MAX, 1'b0);
    set_span(prr_pkg::span_t'(2));
    send_item(prr_pkg::sample_t'(7), 1'b1);
    send_item(prr_pkg::sample_t'(-7), 1'b0);
    send_item(prr_pkg::sample_t'(7), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      span_now = (p == PHASES - 1) ? int'($urandom_range(0, 255)) : phase_span[p];
      set_span(prr_pkg::span_t'(span_now));
      quiet = (p == 1 || p == 6);
      // restarts rare enough that the window usually fills
      for (int i = 0; i < phase_items[p]; i++)
        send_item(pick_sample(),
                  (i == 0 && p % 2 == 0) || $urandom_range(0, 3 * (span_now + 1)) == 0);
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (rx_count == HOLD_AT) ? HOLD_CYCLES : gap_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      rx_count++;
      @(negedge clk);
    end
  end

  // no transaction on either channel for too long means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
